@@ rtl/lpt_pkg.sv @@
// Shared constants and control structs for the patience-sorting tail tracker.
package lpt_pkg;

  // Width of the reported length field on the result channel.
  localparam int unsigned LEN_OUT_W = 11;

  // Tail memory port strobes.
  typedef struct packed {
    logic we;
    logic re;
  } lpt_mem_ctl_t;

  // Result status from the search core.
  typedef struct packed {
    logic done;
    logic is_final;
    logic overflow;
  } lpt_result_t;

endpackage

@@ rtl/lpt_in_if.sv @@
// Input item channel: valid/ready handshake with value and last flag.
interface lpt_in_if #(
  parameter int unsigned VALUE_WIDTH = 32
);
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] value;
  logic                          last;

  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);
endinterface

@@ rtl/lpt_out_if.sv @@
// Result channel: valid/ready handshake with running length and flags.
interface lpt_out_if;
  logic                            valid;
  logic                            ready;
  logic [lpt_pkg::LEN_OUT_W-1:0]   lis_length;
  logic                            is_final;
  logic                            overflow;

  modport source (output valid, output lis_length, output is_final, output overflow,
                  input ready);
  modport sink   (input valid, input lis_length, input is_final, input overflow,
                  output ready);
endinterface

@@ rtl/lpt_tail_ram.sv @@
// Tail store: single write port, single read port, registered read data.
module lpt_tail_ram #(
  parameter int unsigned DEPTH  = 1024,
  parameter int unsigned ADDR_W = 10,
  parameter int unsigned DATA_W = 32
) (
  input  logic                  clk_i,
  input  lpt_pkg::lpt_mem_ctl_t ctl_i,
  input  logic [ADDR_W-1:0]     waddr_i,
  input  logic [DATA_W-1:0]     wdata_i,
  input  logic [ADDR_W-1:0]     raddr_i,
  output logic [DATA_W-1:0]     rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  // Write the tail on request.
  always_ff @(posedge clk_i) begin
    if (ctl_i.we) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Register the read word.
  always_ff @(posedge clk_i) begin
    if (ctl_i.re) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/lpt_core.sv @@
// Search sequencer: length tracking, lower-bound search and tail update.
module lpt_core #(
  parameter int unsigned MAX_LEN     = 1024,
  parameter int unsigned VALUE_WIDTH = 32,
  parameter int unsigned ADDR_W      = 10,
  parameter int unsigned LEN_W       = 11
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic signed [VALUE_WIDTH-1:0] value_i,
  input  logic                          last_i,
  input  logic                          ack_i,
  output logic                          idle_o,
  output lpt_pkg::lpt_result_t          res_o,
  output logic [LEN_W-1:0]              len_o,
  output lpt_pkg::lpt_mem_ctl_t         mem_ctl_o,
  output logic [ADDR_W-1:0]             mem_waddr_o,
  output logic [VALUE_WIDTH-1:0]        mem_wdata_o,
  output logic [ADDR_W-1:0]             mem_raddr_o,
  input  logic [VALUE_WIDTH-1:0]        mem_rdata_i
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CMP  = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  localparam logic [LEN_W-1:0] LenMax = LEN_W'(MAX_LEN);
  localparam logic [LEN_W-1:0] LenOne = LEN_W'(1);

  logic [1:0]                    state_q, state_d;
  logic [LEN_W-1:0]              len_q, len_d;
  logic                          ovf_q, ovf_d;
  logic                          first_q, first_d;
  logic signed [VALUE_WIDTH-1:0] key_q, key_d;
  logic                          last_q, last_d;
  logic [ADDR_W-1:0]             lo_q, lo_d, hi_q, hi_d, mid_q, mid_d;

  logic [LEN_W-1:0]  len_m1;
  logic              tail_lt;
  logic [ADDR_W-1:0] lo_n, hi_n, mid_n;
  logic [ADDR_W:0]   mid_sum;

  assign len_m1  = len_q - LenOne;
  assign tail_lt = $signed(mem_rdata_i) < key_q;

  // Narrow the search window from the probed tail.
  always_comb begin
    if (first_q) begin
      lo_n = '0;
      hi_n = len_m1[ADDR_W-1:0];
    end else if (tail_lt) begin
      lo_n = mid_q + ADDR_W'(1);
      hi_n = hi_q;
    end else begin
      lo_n = lo_q;
      hi_n = mid_q;
    end
  end

  assign mid_sum = {1'b0, lo_n} + {1'b0, hi_n};
  assign mid_n   = mid_sum[ADDR_W:1];

  // Sequence one item: probe last tail (unless the store is empty), search, write back, hand off.
  always_comb begin
    state_d     = state_q;
    len_d       = len_q;
    ovf_d       = ovf_q;
    first_d     = first_q;
    key_d       = key_q;
    last_d      = last_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    mid_d       = mid_q;
    mem_ctl_o   = '0;
    mem_waddr_o = '0;
    mem_wdata_o = key_q;
    mem_raddr_o = mid_n;
    res_o       = '0;

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          key_d  = value_i;
          last_d = last_i;
          if (len_q == '0) begin
            mem_ctl_o.we = 1'b1;
            mem_wdata_o  = value_i;
            len_d        = LenOne;
            state_d      = S_FIN;
          end else begin
            mem_ctl_o.re = 1'b1;
            mem_raddr_o  = len_m1[ADDR_W-1:0];
            first_d      = 1'b1;
            state_d      = S_CMP;
          end
        end
      end
      S_CMP: begin
        if (first_q && tail_lt) begin
          // Append past the last tail, or flag a full store.
          if (len_q < LenMax) begin
            mem_ctl_o.we = 1'b1;
            mem_waddr_o  = len_q[ADDR_W-1:0];
            len_d        = len_q + LenOne;
          end else begin
            ovf_d = 1'b1;
          end
          state_d = S_FIN;
        end else if (lo_n == hi_n) begin
          // Replace the first tail not smaller than the key.
          mem_ctl_o.we = 1'b1;
          mem_waddr_o  = lo_n;
          state_d      = S_FIN;
        end else begin
          mem_ctl_o.re = 1'b1;
          lo_d         = lo_n;
          hi_d         = hi_n;
          mid_d        = mid_n;
          first_d      = 1'b0;
        end
      end
      S_FIN: begin
        res_o.done     = 1'b1;
        res_o.is_final = last_q;
        res_o.overflow = ovf_q;
        if (ack_i) begin
          state_d = S_IDLE;
          if (last_q) begin
            len_d = '0;
            ovf_d = 1'b0;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Hold control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      len_q   <= '0;
      ovf_q   <= 1'b0;
      first_q <= 1'b0;
    end else begin
      state_q <= state_d;
      len_q   <= len_d;
      ovf_q   <= ovf_d;
      first_q <= first_d;
    end
  end

  // Hold the item and the search window.
  always_ff @(posedge clk_i) begin
    key_q  <= key_d;
    last_q <= last_d;
    lo_q   <= lo_d;
    hi_q   <= hi_d;
    mid_q  <= mid_d;
  end

  assign idle_o = (state_q == S_IDLE);
  assign len_o  = len_q;

endmodule

@@ rtl/lis_patience_tails.sv @@
// Top level: longest increasing subsequence tracker over a tail memory.
//
//   channel   dir  handshake          payload
//   data_i    in   valid / ready      value, last
//   res_o     out  valid / ready      lis_length, is_final, overflow
//
// An empty store takes the item at once; otherwise the last tail is probed,
// and an item that neither appends nor hits a full store searches for the
// tail it replaces, one probe per cycle through the tail memory's single
// read port. Reset clears the control state, length and overflow only;
// tails are written before they are read, so no clearing pass runs.
// A stalled result waits in the output register while the next item runs;
// a second finished result holds the core until the register drains.
module lis_patience_tails #(
  parameter int unsigned MAX_LEN     = 1024,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  lpt_in_if.sink    data_i,
  lpt_out_if.source res_o
);

  localparam int unsigned AddrW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int unsigned LenW  = $clog2(MAX_LEN + 1);
  localparam int unsigned OutW  = lpt_pkg::LEN_OUT_W;

  logic                  core_idle;
  lpt_pkg::lpt_result_t  core_res;
  logic [LenW-1:0]       core_len;
  lpt_pkg::lpt_mem_ctl_t mem_ctl;
  logic [AddrW-1:0]      mem_waddr, mem_raddr;
  logic [VALUE_WIDTH-1:0] mem_wdata, mem_rdata;

  logic                  in_take, out_load;
  logic                  out_valid_q;
  logic [LenW-1:0]       out_len_q;
  logic                  out_fin_q, out_ovf_q;
  logic [LenW+OutW-1:0]  out_len_ext;

  assign data_i.ready = core_idle;
  assign in_take      = data_i.valid & data_i.ready;
  assign out_load     = core_res.done & (~out_valid_q | res_o.ready);

  lpt_core #(
    .MAX_LEN     (MAX_LEN),
    .VALUE_WIDTH (VALUE_WIDTH),
    .ADDR_W      (AddrW),
    .LEN_W       (LenW)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (in_take),
    .value_i     (data_i.value),
    .last_i      (data_i.last),
    .ack_i       (out_load),
    .idle_o      (core_idle),
    .res_o       (core_res),
    .len_o       (core_len),
    .mem_ctl_o   (mem_ctl),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  lpt_tail_ram #(
    .DEPTH  (MAX_LEN),
    .ADDR_W (AddrW),
    .DATA_W (VALUE_WIDTH)
  ) u_tail_ram (
    .clk_i   (clk_i),
    .ctl_i   (mem_ctl),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Track output register occupancy.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Load the result transaction.
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_len_q <= core_len;
      out_fin_q <= core_res.is_final;
      out_ovf_q <= core_res.overflow;
    end
  end

  assign out_len_ext      = {{OutW{1'b0}}, out_len_q};
  assign res_o.valid      = out_valid_q;
  assign res_o.lis_length = out_len_ext[OutW-1:0];
  assign res_o.is_final   = out_fin_q;
  assign res_o.overflow   = out_ovf_q;

  // An accepted item keeps the input closed until the core finishes.
  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take |=> !data_i.ready)
    else $error("input ready while an item is in flight");

  // A finished result that has not been handed off blocks new items.
  a_done_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    core_res.done |-> !data_i.ready)
    else $error("input ready while a result waits in the core");

  // Overflow is only reported with a full store.
  a_ovf_at_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.overflow) |-> (out_len_q == LenW'(MAX_LEN)))
    else $error("overflow reported below full length");

endmodule

@@ tb/tb_lis_patience_tails.sv @@
`timescale 1ns / 100ps
// Testbench for the patience-sorting longest increasing subsequence tracker.
module tb_lis_patience_tails;

  localparam int unsigned MAX_LEN      = 1024;
  localparam int unsigned VALUE_W      = 32;
  localparam int unsigned IDLE_PCT     = 37;
  localparam int unsigned ITEMS_TOTAL  = 1750;
  localparam int unsigned LONG_AT      = 500;
  localparam int unsigned HOLD_START   = 1500;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned STEADY_START = 5000;
  localparam int unsigned STEADY_END   = 8000;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned TIMEOUT_NS   = 4_000_000;
  localparam int unsigned NUM_ROWS     = 24;

  typedef struct packed {
    logic [lpt_pkg::LEN_OUT_W-1:0] lis_length;
    logic                          is_final;
    logic                          overflow;
  } lis_res_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      last;
    logic                      typed;
    lis_res_t                  res;
  } stim_row_t;

  // Directed rows: typed results where the answer is obvious, else predicted.
  localparam stim_row_t DIR_ROWS [NUM_ROWS] = '{
    '{32'sh0000_0000, 1'b1, 1'b1, '{11'd1, 1'b1, 1'b0}},
    '{32'sh8000_0000, 1'b0, 1'b1, '{11'd1, 1'b0, 1'b0}},
    '{32'sh8000_0000, 1'b0, 1'b1, '{11'd1, 1'b0, 1'b0}},
    '{32'sh7fff_ffff, 1'b0, 1'b1, '{11'd2, 1'b0, 1'b0}},
    '{32'sh7fff_ffff, 1'b0, 1'b1, '{11'd2, 1'b0, 1'b0}},
    '{32'shffff_ffff, 1'b0, 1'b0, '0},
    '{32'sh0000_0000, 1'b0, 1'b0, '0},
    '{32'shffff_fffb, 1'b0, 1'b0, '0},
    '{32'sh0000_0001, 1'b0, 1'b0, '0},
    '{32'sh8000_0000, 1'b1, 1'b0, '0},
    '{32'sh0000_0064, 1'b0, 1'b1, '{11'd1, 1'b0, 1'b0}},
    '{32'sh0000_0032, 1'b0, 1'b1, '{11'd1, 1'b0, 1'b0}},
    '{32'sh0000_0019, 1'b0, 1'b1, '{11'd1, 1'b0, 1'b0}},
    '{32'sh0000_000a, 1'b1, 1'b1, '{11'd1, 1'b1, 1'b0}},
    '{32'sh7fff_fffe, 1'b0, 1'b1, '{11'd1, 1'b0, 1'b0}},
    '{32'sh8000_0001, 1'b0, 1'b1, '{11'd1, 1'b0, 1'b0}},
    '{32'sh5555_5555, 1'b0, 1'b0, '0},
    '{32'sh2aaa_aaaa, 1'b0, 1'b0, '0},
    '{32'sh3000_0000, 1'b0, 1'b0, '0},
    '{32'sh7fff_ffff, 1'b0, 1'b0, '0},
    '{32'shaaaa_aaaa, 1'b1, 1'b0, '0},
    '{32'sh0000_0003, 1'b0, 1'b1, '{11'd1, 1'b0, 1'b0}},
    '{32'sh0000_0003, 1'b0, 1'b1, '{11'd1, 1'b0, 1'b0}},
    '{32'sh0000_0003, 1'b1, 1'b1, '{11'd1, 1'b1, 1'b0}}
  };

  logic clk = 1'b0;
  logic rst_n;

  lpt_in_if #(.VALUE_WIDTH(VALUE_W)) data_if ();
  lpt_out_if                         res_if ();

  lis_patience_tails #(
    .MAX_LEN     (MAX_LEN),
    .VALUE_WIDTH (VALUE_W)
  ) u_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .data_i (data_if.sink),
    .res_o  (res_if.source)
  );

  // Predictor state: smallest tail per length, running length, overflow flag.
  logic signed [VALUE_W-1:0] lis_tails [MAX_LEN];
  int unsigned               lis_len;
  logic                      lis_ovf;

  lis_res_t    lis_expected [$];
  lis_res_t    lis_head;
  int unsigned err_count;
  int unsigned items_sent;
  int unsigned rcv_cycle;
  bit          src_steady;

  // Clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 0;
  end

  // Advance the tails for one value and return the running result.
  function automatic lis_res_t lis_track(logic signed [VALUE_W-1:0] v, logic fin);
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    lis_res_t    r;
    if (lis_len == 0 || lis_tails[lis_len-1] < v) begin
      if (lis_len < MAX_LEN) begin
        lis_tails[lis_len] = v;
        lis_len++;
      end else begin
        lis_ovf = 1'b1;
      end
    end else begin
      lo = 0;
      hi = lis_len;
      while (lo < hi) begin
        mid = (lo + hi) / 2;
        if (lis_tails[mid] < v) lo = mid + 1;
        else hi = mid;
      end
      lis_tails[lo] = v;
    end
    r.lis_length = lis_len[lpt_pkg::LEN_OUT_W-1:0];
    r.is_final   = fin;
    r.overflow   = lis_ovf;
    if (fin) begin
      lis_len = 0;
      lis_ovf = 1'b0;
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
    err_count++;
  endtask

  // Offer one item with random gaps (none while the source is steady); record its expected result on acceptance.
  task automatic send_item(input logic signed [VALUE_W-1:0] v, input logic fin,
                           input logic typed, input lis_res_t typed_res);
    lis_res_t pred;
    @(negedge clk);
    while (!src_steady && $urandom_range(0, 99) < IDLE_PCT) begin
      data_if.valid <= 1'b0;
      @(negedge clk);
    end
    data_if.valid <= 1'b1;
    data_if.value <= v;
    data_if.last  <= fin;
    do @(posedge clk); while (!data_if.ready);
    pred = lis_track(v, fin);
    lis_expected.push_back(typed ? typed_res : pred);
    items_sent++;
  endtask

  // Receiver: random stalls, one long hold-off and one stretch with no stalls.
  always @(negedge clk) begin
    if (rst_n) begin
      rcv_cycle <= rcv_cycle + 1;
      if (rcv_cycle >= HOLD_START && rcv_cycle < HOLD_START + HOLD_CYCLES)
        res_if.ready <= 1'b0;
      else if (rcv_cycle >= STEADY_START && rcv_cycle < STEADY_END)
        res_if.ready <= 1'b1;
      else
        res_if.ready <= ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // Check each result transaction against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && res_if.valid && res_if.ready) begin
      if (lis_expected.size() == 0) begin
        report_mismatch("unexpected result, length", res_if.lis_length, 0);
      end else begin
        lis_head = lis_expected.pop_front();
        if (res_if.lis_length !== lis_head.lis_length)
          report_mismatch("lis_length", res_if.lis_length, lis_head.lis_length);
        if (res_if.is_final !== lis_head.is_final)
          report_mismatch("is_final", res_if.is_final, lis_head.is_final);
        if (res_if.overflow !== lis_head.overflow)
          report_mismatch("overflow", res_if.overflow, lis_head.overflow);
      end
    end
  end

  // Stimulus
  initial begin
    int                        kind;
    int                        seq_len;
    int                        cur;
    int                        extra;
    bit                        long_done;
    logic signed [VALUE_W-1:0] v;
    rst_n         = 1'b0;
    data_if.valid = 1'b0;
    data_if.value = '0;
    data_if.last  = 1'b0;
    res_if.ready  = 1'b0;
    lis_len       = 0;
    lis_ovf       = 1'b0;
    err_count     = 0;
    items_sent    = 0;
    rcv_cycle     = 0;
    src_steady    = 1'b0;
    long_done     = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed table
    for (int i = 0; i < NUM_ROWS; i++)
      send_item(DIR_ROWS[i].value, DIR_ROWS[i].last, DIR_ROWS[i].typed, DIR_ROWS[i].res);

    // Random sequences, with one long rising run that fills the tail store
    while (items_sent < ITEMS_TOTAL) begin
      if (!long_done && items_sent >= LONG_AT) begin
        long_done  = 1'b1;
        src_steady = 1'b1;
        cur        = int'($urandom_range(0, 1 << 20)) - (1 << 19);
        extra      = 0;
        while (extra < 24) begin
          if ($urandom_range(0, 99) < 8) begin
            v = cur - int'($urandom_range(0, 200000));
          end else begin
            cur = cur + int'($urandom_range(1, 3000));
            v   = cur;
          end
          send_item(v, 1'b0, 1'b0, '0);
          if (lis_len >= 400) src_steady = 1'b0;
          if (lis_ovf) extra++;
        end
        send_item(cur + 1, 1'b1, 1'b0, '0);
      end
      kind    = $urandom_range(0, 2);
      seq_len = $urandom_range(1, 48);
      cur     = $urandom;
      for (int k = 0; k < seq_len; k++) begin
        case (kind)
          0: v = $urandom;
          1: begin
            // mostly rising with occasional dips
            cur = cur + int'($urandom_range(0, 64)) - 8;
            v   = cur;
          end
          default: v = int'($urandom_range(0, 7)) - 4;
        endcase
        send_item(v, k == seq_len - 1, 1'b0, '0);
      end
    end

    // Drain
    @(negedge clk);
    data_if.valid <= 1'b0;
    while (lis_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(TIMEOUT_NS);
    $display("CHECK FAILED");
    $finish;
  end

endmodule
